/* hdl/adpb_pkg.sv */
// ----------------------------------------------------------------------------
// adpb_pkg
// Shared widths, configuration register codes and beat types for the
// antialiased disc pixel blend block.
// ----------------------------------------------------------------------------
package adpb_pkg;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 4;
	localparam int CENTER_BITS = COORD_BITS + FRAC_BITS;
	localparam int RADIUS_BITS = 8 + FRAC_BITS;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int COLOR_BITS  = 24;
	localparam int CHAN_BITS   = 8;
	localparam int COV_BITS    = 9;
	localparam int COV_FULL    = 256;

	localparam int SQ_BITS     = 2 * CENTER_BITS;
	localparam int D_BITS      = SQ_BITS + 1;
	localparam int RR_BITS     = 2 * RADIUS_BITS;
	localparam int OUTER_BITS  = 2 * RADIUS_BITS + 2;
	localparam int CMP_BITS    = (D_BITS + 1 > OUTER_BITS) ? D_BITS + 1 : OUTER_BITS;
	localparam int RAMP_BITS   = RADIUS_BITS + FRAC_BITS + 2;

	localparam int QUO_BITS       = 8;
	localparam int DIV_STAGES     = 4;
	localparam int BITS_PER_STAGE = QUO_BITS / DIV_STAGES;
	localparam int PIPE_LATENCY   = 5 + DIV_STAGES;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_RADIUS,
		CFG_RIM_COLOR,
		CFG_CORE_COLOR
	} cfg_idx_t;

	localparam logic [CENTER_BITS-1:0] CENTER_X_RST = CENTER_BITS'(2560);
	localparam logic [CENTER_BITS-1:0] CENTER_Y_RST = CENTER_BITS'(1920);
	localparam logic [RADIUS_BITS-1:0] RADIUS_RST   = RADIUS_BITS'(576);
	localparam logic [COLOR_BITS-1:0]  RIM_RST      = 24'hB48CFF;
	localparam logic [COLOR_BITS-1:0]  CORE_RST     = 24'hFFFFFF;

	typedef struct packed {
		logic [CENTER_BITS-1:0] center_x;
		logic [CENTER_BITS-1:0] center_y;
		logic [RADIUS_BITS-1:0] radius;
		logic [COLOR_BITS-1:0]  rim_color;
		logic [COLOR_BITS-1:0]  core_color;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [COLOR_BITS-1:0] dest_color;
	} pix_in_t;

	typedef struct packed {
		logic [COLOR_BITS-1:0] new_color;
		logic                  written;
		logic [COV_BITS-1:0]   coverage;
	} pix_out_t;

	typedef struct packed {
		logic                  written;
		logic                  full;
		logic [COLOR_BITS-1:0] src;
		logic [COLOR_BITS-1:0] dst;
		logic [RAMP_BITS:0]    rem;
		logic [RAMP_BITS-1:0]  dvs;
		logic [QUO_BITS-1:0]   quo;
	} div_t;

endpackage

/* hdl/adpb_cfg.sv */
// ----------------------------------------------------------------------------
// adpb_cfg
// Configuration register file written over its own valid/ready channel.
// ----------------------------------------------------------------------------
module adpb_cfg import adpb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= CENTER_X_RST;
			cfg_q.center_y   <= CENTER_Y_RST;
			cfg_q.radius     <= RADIUS_RST;
			cfg_q.rim_color  <= RIM_RST;
			cfg_q.core_color <= CORE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X:   cfg_q.center_x   <= cfg_data[CENTER_BITS-1:0];
				CFG_CENTER_Y:   cfg_q.center_y   <= cfg_data[CENTER_BITS-1:0];
				CFG_RADIUS:     cfg_q.radius     <= cfg_data[RADIUS_BITS-1:0];
				CFG_RIM_COLOR:  cfg_q.rim_color  <= cfg_data[COLOR_BITS-1:0];
				CFG_CORE_COLOR: cfg_q.core_color <= cfg_data[COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* hdl/adpb_geom.sv */
// ----------------------------------------------------------------------------
// adpb_geom
// Four pipeline stages: distance offsets, squares, squared distance, and
// classification into core, ramp or outside with the ramp numerator.
// ----------------------------------------------------------------------------
module adpb_geom import adpb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	input  pix_in_t pixel,
	output logic    out_valid,
	output div_t    out_data
);

	logic [CENTER_BITS-1:0]  px_c, py_c;
	logic [RADIUS_BITS-1:0]  one_c, rin_c;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [CENTER_BITS-1:0]  dx_s1, dy_s1;
	logic [RADIUS_BITS-1:0]  rin_s1;
	logic [RADIUS_BITS:0]    rp1_s1;
	logic [COLOR_BITS-1:0]   dst_s1, dst_s2, dst_s3;

	logic [SQ_BITS-1:0]      dxx_s2, dyy_s2;
	logic [RR_BITS-1:0]      rr_s2, inner_s2;
	logic [OUTER_BITS-1:0]   outer_s2;

	logic [D_BITS-1:0]       d_s3;
	logic [RR_BITS-1:0]      rr_s3, inner_s3;
	logic [OUTER_BITS-1:0]   outer_s3;

	logic [CMP_BITS-1:0]     d_c, d2_c, rr_c, inner_c, outer_c;
	logic                    core_c, outside_c, rim_c;
	div_t                    data_c, data_s4;

	assign px_c  = CENTER_BITS'(pixel.pixel_x) << FRAC_BITS;
	assign py_c  = CENTER_BITS'(pixel.pixel_y) << FRAC_BITS;
	assign one_c = RADIUS_BITS'(ONE);
	assign rin_c = (cfg.radius >= one_c) ? cfg.radius - one_c : one_c - cfg.radius;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= (px_c >= cfg.center_x) ? px_c - cfg.center_x : cfg.center_x - px_c;
		dy_s1    <= (py_c >= cfg.center_y) ? py_c - cfg.center_y : cfg.center_y - py_c;
		rin_s1   <= rin_c;
		rp1_s1   <= {1'b0, cfg.radius} + (RADIUS_BITS+1)'(ONE);
		dst_s1   <= pixel.dest_color;

		dxx_s2   <= SQ_BITS'(dx_s1) * SQ_BITS'(dx_s1);
		dyy_s2   <= SQ_BITS'(dy_s1) * SQ_BITS'(dy_s1);
		rr_s2    <= RR_BITS'(cfg.radius) * RR_BITS'(cfg.radius);
		inner_s2 <= RR_BITS'(rin_s1) * RR_BITS'(rin_s1);
		outer_s2 <= OUTER_BITS'(rp1_s1) * OUTER_BITS'(rp1_s1);
		dst_s2   <= dst_s1;

		d_s3     <= D_BITS'(dxx_s2) + D_BITS'(dyy_s2);
		rr_s3    <= rr_s2;
		inner_s3 <= inner_s2;
		outer_s3 <= outer_s2;
		dst_s3   <= dst_s2;

		data_s4  <= data_c;
	end

	assign d_c       = CMP_BITS'(d_s3);
	assign d2_c      = CMP_BITS'(d_s3) << 1;
	assign rr_c      = CMP_BITS'(rr_s3);
	assign inner_c   = CMP_BITS'(inner_s3);
	assign outer_c   = CMP_BITS'(outer_s3);
	assign core_c    = d_c <= inner_c;
	assign outside_c = d_c >= outer_c;
	assign rim_c     = d2_c >= rr_c;

	always_comb begin
		data_c.written = !outside_c;
		data_c.full    = core_c;
		data_c.src     = rim_c ? cfg.rim_color : cfg.core_color;
		data_c.dst     = dst_s3;
		data_c.dvs     = RAMP_BITS'(cfg.radius) << (FRAC_BITS + 2);
		data_c.quo     = '0;
		if (!core_c && !outside_c) begin
			data_c.rem = (RAMP_BITS+1)'(RAMP_BITS'(outer_c - d_c));
		end else begin
			data_c.rem = '0;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule

/* hdl/adpb_div_stage.sv */
// ----------------------------------------------------------------------------
// adpb_div_stage
// One stage of the restoring coverage divider; resolves two quotient bits.
// ----------------------------------------------------------------------------
module adpb_div_stage import adpb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  div_t in_data,
	output logic out_valid,
	output div_t out_data
);

	logic               valid_s1;
	div_t               data_s1;
	div_t               data_c;
	logic [RAMP_BITS:0] shifted;

	always_comb begin
		data_c  = in_data;
		shifted = '0;
		for (int k = 0; k < BITS_PER_STAGE; k++) begin
			shifted = {data_c.rem[RAMP_BITS-1:0], 1'b0};
			if (shifted >= {1'b0, data_c.dvs}) begin
				data_c.rem = shifted - {1'b0, data_c.dvs};
				data_c.quo = {data_c.quo[QUO_BITS-2:0], 1'b1};
			end else begin
				data_c.rem = shifted;
				data_c.quo = {data_c.quo[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= data_c;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// The partial remainder of a ramp pixel always stays below the divisor.
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && data_s1.written && !data_s1.full |-> data_s1.rem < {1'b0, data_s1.dvs})
		else $error("divider remainder not below divisor");

endmodule

/* hdl/adpb_blend.sv */
// ----------------------------------------------------------------------------
// adpb_blend
// Final stage: picks the coverage and blends the source color over the
// destination per channel.
// ----------------------------------------------------------------------------
module adpb_blend import adpb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  div_t     in_data,
	output logic     done,
	output pix_out_t result
);

	logic [COV_BITS-1:0] cov_c, inv_c;
	pix_out_t            res_c, res_s1;
	logic                done_s1;

	always_comb begin
		logic [2*CHAN_BITS:0] acc;
		if (!in_data.written) begin
			cov_c = '0;
		end else if (in_data.full) begin
			cov_c = COV_BITS'(COV_FULL);
		end else begin
			cov_c = COV_BITS'(in_data.quo);
		end
		inv_c = COV_BITS'(COV_FULL) - cov_c;
		res_c.written  = in_data.written;
		res_c.coverage = cov_c;
		for (int c = 0; c < 3; c++) begin
			acc = (2*CHAN_BITS+1)'(in_data.src[c*CHAN_BITS +: CHAN_BITS]) * (2*CHAN_BITS+1)'(cov_c)
				+ (2*CHAN_BITS+1)'(in_data.dst[c*CHAN_BITS +: CHAN_BITS])
				* (2*CHAN_BITS+1)'(inv_c);
			res_c.new_color[c*CHAN_BITS +: CHAN_BITS] = acc[2*CHAN_BITS-1:CHAN_BITS];
		end
		if (!in_data.written) begin
			res_c.new_color = in_data.dst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= res_c;
	end

	assign done   = done_s1;
	assign result = res_s1;

	// Any nonzero coverage comes only from a pixel inside the outer bound.
	a_cov_written: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.coverage != '0 |-> result.written)
		else $error("coverage reported for an untouched pixel");

	a_cov_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.coverage <= COV_BITS'(COV_FULL))
		else $error("coverage above full scale");

endmodule

/* hdl/antialiased_disc_pixel_blend.sv */
// ----------------------------------------------------------------------------
// antialiased_disc_pixel_blend
// Per-pixel shader that draws an antialiased filled disc over a pixel stream.
//
// A pixel beat (coordinate and current color) is taken at a clock edge with
// start high and busy low. busy is high only during reset and the first clock
// after it; afterward one pixel can be taken in every cycle.
// Each result beat appears on result for one cycle with done high, in input
// order. The pipeline consists of four geometry stages (offset, square,
// sum, classify), four stages of the restoring coverage divider at two
// quotient bits each, and the blend stage.
// The receiver cannot stall, so the pipeline never holds.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while no pixel is in flight.
// Reset restores the default disc and empties the pipeline.
// ----------------------------------------------------------------------------
module antialiased_disc_pixel_blend import adpb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  pix_in_t                  pixel,
	output logic                     done,
	output pix_out_t                 result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t  cfg;
	logic  busy_q;
	logic  geo_valid;
	div_t  geo_data;
	logic  dv [DIV_STAGES+1];
	div_t  dd [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	adpb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	adpb_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (start && !busy_q),
		.pixel     (pixel),
		.out_valid (geo_valid),
		.out_data  (geo_data)
	);

	assign dv[0] = geo_valid;
	assign dd[0] = geo_data;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		adpb_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[i]),
			.in_data   (dd[i]),
			.out_valid (dv[i+1]),
			.out_data  (dd[i+1])
		);
	end

	adpb_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv[DIV_STAGES]),
		.in_data  (dd[DIV_STAGES]),
		.done     (done),
		.result   (result)
	);

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LATENCY done)
		else $error("accepted pixel produced no result beat");

	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result beat without an accepted pixel");

endmodule

/* tb/antialiased_disc_pixel_blend_tb.sv */
// ----------------------------------------------------------------------------
// antialiased_disc_pixel_blend_tb
// Self-checking bench for the antialiased disc pixel blend block.
//
// A queue of pixel beats feeds a clocked driver. Each pixel that the block
// takes is shaded by a behavioral disc shader in the bench, which keeps its
// own copy of the disc registers. A clocked monitor compares every result
// beat, field by field, with the oldest shaded pixel still waiting.
// Directed pixels hit the fill boundaries, the rim and core split, the
// near-zero edge ramp and tiny radii. Random phases then change the disc
// between runs and mostly aim pixels at the antialiased rim, with sender
// gaps of varying density.
// ----------------------------------------------------------------------------
module antialiased_disc_pixel_blend_tb;
	import adpb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_FIRST =
		CFG_IDX_BITS'(int'(CFG_CORE_COLOR) + 1);
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_PIXELS  = 150;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	pix_in_t                  pixel = '0;
	logic                     done;
	pix_out_t                 result;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	cfg_t        disc;
	pix_in_t     pixel_queue[$];
	pix_out_t    shade_q[$];
	logic        pix_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned calm_left = 0;
	int unsigned mismatches = 0;
	int unsigned n_full = 0;
	int unsigned n_ramp = 0;
	int unsigned n_zero = 0;
	int unsigned n_untouched = 0;
	int unsigned n_settings = 1;

	antialiased_disc_pixel_blend dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic pix_out_t shade_pixel(pix_in_t p, cfg_t c);
		longint unsigned px, py, dx, dy, dsq, rr, rin, inner, outer, cov, s, d;
		logic [COLOR_BITS-1:0] src;
		pix_out_t o;
		px = 64'(p.pixel_x) << FRAC_BITS;
		py = 64'(p.pixel_y) << FRAC_BITS;
		dx = (px >= c.center_x) ? px - c.center_x : c.center_x - px;
		dy = (py >= c.center_y) ? py - c.center_y : c.center_y - py;
		dsq = dx * dx + dy * dy;
		rr = 64'(c.radius) * c.radius;
		rin = (c.radius >= ONE) ? c.radius - ONE : ONE - c.radius;
		inner = rin * rin;
		outer = (64'(c.radius) + ONE) * (64'(c.radius) + ONE);
		if (dsq <= inner) begin
			cov = COV_FULL;
		end else if (dsq >= outer) begin
			o.new_color = p.dest_color;
			o.written = 1'b0;
			o.coverage = '0;
			return o;
		end else begin
			cov = ((outer - dsq) << 8) / (outer - inner);
			if (cov > COV_FULL)
				cov = COV_FULL;
		end
		src = (2 * dsq >= rr) ? c.rim_color : c.core_color;
		for (int k = 0; k < 3; k++) begin
			s = src[CHAN_BITS*k +: CHAN_BITS];
			d = p.dest_color[CHAN_BITS*k +: CHAN_BITS];
			o.new_color[CHAN_BITS*k +: CHAN_BITS] = CHAN_BITS'((s * cov + d * (COV_FULL - cov)) >> 8);
		end
		o.written = 1'b1;
		o.coverage = COV_BITS'(cov);
		return o;
	endfunction

	// Pixels around the current disc, either hugging the rim or anywhere in its box.
	function automatic pix_in_t disc_pixel(bit on_rim);
		pix_in_t p;
		real rpx, h;
		int span, dx, dy, cxp, cyp;
		rpx = real'(disc.radius) / ONE;
		span = int'(rpx) + 2;
		cxp = int'(disc.center_x >> FRAC_BITS);
		cyp = int'(disc.center_y >> FRAC_BITS);
		dx = int'($urandom_range(0, 2 * span)) - span;
		if (on_rim) begin
			h = rpx * rpx - real'(dx * dx);
			dy = (h > 0.0) ? $rtoi($sqrt(h)) : 0;
			dy = dy + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(1))
				dy = -dy;
		end else begin
			dy = int'($urandom_range(0, 2 * span)) - span;
		end
		p.pixel_x = COORD_BITS'(cxp + dx);
		p.pixel_y = COORD_BITS'(cyp + dy);
		p.dest_color = COLOR_BITS'($urandom);
		return p;
	endfunction

	task automatic push_pixel(int x, int y, logic [COLOR_BITS-1:0] color);
		pixel_queue.push_back('{pixel_x: COORD_BITS'(x), pixel_y: COORD_BITS'(y),
			dest_color: color});
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CENTER_X:   disc.center_x = data[CENTER_BITS-1:0];
			CFG_CENTER_Y:   disc.center_y = data[CENTER_BITS-1:0];
			CFG_RADIUS:     disc.radius = data[RADIUS_BITS-1:0];
			CFG_RIM_COLOR:  disc.rim_color = data[COLOR_BITS-1:0];
			CFG_CORE_COLOR: disc.core_color = data[COLOR_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (pixel_queue.size() != 0 || start || shade_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	always @(negedge clk) begin : feed
		if (!start || pix_taken) begin
			if (calm_left > 0)
				calm_left <= calm_left - 1;
			else if ($urandom_range(49) == 0)
				calm_left <= $urandom_range(10, 40);
			if (pixel_queue.size() != 0 &&
					(calm_left > 0 || $urandom_range(99) >= send_idle_pct)) begin
				pixel <= pixel_queue.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : take
		pix_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			shade_q.push_back(shade_pixel(pixel, disc));
	end

	always @(posedge clk) begin : check
		pix_out_t want;
		if (arst_n && done) begin
			if (shade_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, result);
				mismatches++;
			end else begin
				want = shade_q.pop_front();
				if (!want.written)
					n_untouched++;
				else if (want.coverage == COV_FULL)
					n_full++;
				else
					n_ramp++;
				if (want.written && want.coverage == 0)
					n_zero++;
				if (result.new_color !== want.new_color) begin
					$display("%0t: new_color expected %h actual %h", $time,
						want.new_color, result.new_color);
					mismatches++;
				end
				if (result.written !== want.written) begin
					$display("%0t: written expected %b actual %b", $time,
						want.written, result.written);
					mismatches++;
				end
				if (result.coverage !== want.coverage) begin
					$display("%0t: coverage expected %0d actual %0d", $time,
						want.coverage, result.coverage);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		pix_in_t p;
		pix_out_t o;
		int unsigned hits, tries;
		int unsigned idle_plan[4];
		logic [RADIUS_BITS-1:0] rad;

		idle_plan = '{0, 71, 0, 26};
		disc = '{center_x: CENTER_X_RST, center_y: CENTER_Y_RST, radius: RADIUS_RST,
			rim_color: RIM_RST, core_color: CORE_RST};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default disc: center (160, 120), radius 36 pixels.
		push_pixel(160, 120, 24'h000000);
		push_pixel(160, 120, 24'hFFFFFF);
		push_pixel(0, 0, 24'hFFFFFF);
		push_pixel(4095, 4095, 24'h000000);
		push_pixel(178, 137, 24'h5A5A5A);
		push_pixel(178, 138, 24'h5A5A5A);
		push_pixel(195, 120, 24'h123456);
		push_pixel(196, 120, 24'h000000);
		push_pixel(196, 120, 24'hFFFFFF);
		push_pixel(197, 120, 24'h123456);
		push_pixel(125, 120, 24'hA5C3E1);
		settle();

		// Large disc with fractional center, wide data bits on the center writes.
		write_reg(CFG_CENTER_X, 24'hA58008);
		write_reg(CFG_CENTER_Y, 24'h3C7FF4);
		write_reg(CFG_RADIUS, 24'hF00FFF);
		write_reg(CFG_RIM_COLOR, 24'h000000);
		write_reg(CFG_CORE_COLOR, 24'hFFFFFF);
		hits = 0;
		tries = 0;
		while (hits < 3 && tries < 20000) begin
			p = disc_pixel(1'b1);
			o = shade_pixel(p, disc);
			if (o.written && o.coverage == 0) begin
				pixel_queue.push_back(p);
				hits++;
			end
			tries++;
		end
		pixel_queue.push_back(disc_pixel(1'b1));
		pixel_queue.push_back(disc_pixel(1'b0));
		settle();

		// Sub-pixel radii with center x at the top of its range and center y at zero.
		write_reg(CFG_CENTER_X, 24'h00FFFF);
		write_reg(CFG_CENTER_Y, 24'h000000);
		write_reg(CFG_RADIUS, 24'h000000);
		write_reg(CFG_SPARE_FIRST, 24'hFFFFFF);
		push_pixel(4095, 0, 24'h808080);
		push_pixel(4094, 0, 24'h808080);
		settle();
		write_reg(CFG_RADIUS, 24'h000008);
		push_pixel(4095, 0, 24'h0F0F0F);
		push_pixel(4095, 1, 24'hF0F0F0);
		push_pixel(0, 4095, 24'h00FF00);
		settle();
		n_settings += 3;

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: rad = RADIUS_BITS'(16);
				1: rad = '1;
				default:
					case ($urandom_range(9))
						0: rad = RADIUS_BITS'($urandom_range(0, 15));
						1: rad = RADIUS_BITS'($urandom);
						default: rad = RADIUS_BITS'($urandom_range(16, 800));
					endcase
			endcase
			write_reg(CFG_CENTER_X, (ph == 2) ? 24'h000000 : CFG_DATA_BITS'($urandom));
			write_reg(CFG_CENTER_Y, (ph == 3) ? 24'hFFFFFF : CFG_DATA_BITS'($urandom));
			write_reg(CFG_RADIUS, {CFG_DATA_BITS'($urandom)} & ~24'hFFF | rad);
			write_reg(CFG_RIM_COLOR, CFG_DATA_BITS'($urandom));
			write_reg(CFG_CORE_COLOR, CFG_DATA_BITS'($urandom));
			if ($urandom_range(2) == 0)
				write_reg(CFG_SPARE_FIRST + CFG_IDX_BITS'($urandom_range(0,
					(1 << CFG_IDX_BITS) - 1 - CFG_SPARE_FIRST)), CFG_DATA_BITS'($urandom));
			n_settings++;
			send_idle_pct = idle_plan[ph % 4];
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				case ($urandom_range(9))
					6, 7: p = disc_pixel(1'b0);
					8, 9: p = pix_in_t'(48'({$urandom, $urandom}));
					default: p = disc_pixel(1'b1);
				endcase
				pixel_queue.push_back(p);
			end
			settle();
		end

		$display("Shaded %0d pixels under %0d disc settings: %0d fully covered, %0d on the ramp",
			n_full + n_ramp + n_untouched, n_settings, n_full, n_ramp);
		$display("(%0d of them at zero coverage) and %0d left untouched.", n_zero, n_untouched);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
